// ===== rtl/rne_pkg.sv =====
package rne_pkg;

	localparam int unsigned VALUE_W     = 12;
	localparam int unsigned LETTER_W    = 7;
	localparam int unsigned NUM_WEIGHTS = 13;
	localparam int unsigned IDX_W       = $clog2(NUM_WEIGHTS);
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [VALUE_W-1:0] MAX_VALID = VALUE_W'(3999);

	localparam logic [LETTER_W-1:0] LTR_NONE = 7'h00;
	localparam logic [LETTER_W-1:0] LTR_I    = 7'h69;
	localparam logic [LETTER_W-1:0] LTR_V    = 7'h76;
	localparam logic [LETTER_W-1:0] LTR_X    = 7'h78;
	localparam logic [LETTER_W-1:0] LTR_L    = 7'h6c;
	localparam logic [LETTER_W-1:0] LTR_C    = 7'h63;
	localparam logic [LETTER_W-1:0] LTR_D    = 7'h64;
	localparam logic [LETTER_W-1:0] LTR_M    = 7'h6d;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               range_error;
	} qentry_t;

	typedef struct packed {
		logic valid;
		logic full;
	} qstat_t;

	function automatic logic [VALUE_W-1:0] weight(input logic [IDX_W-1:0] idx);
		case (idx)
			4'd0:    return VALUE_W'(1000);
			4'd1:    return VALUE_W'(900);
			4'd2:    return VALUE_W'(500);
			4'd3:    return VALUE_W'(400);
			4'd4:    return VALUE_W'(100);
			4'd5:    return VALUE_W'(90);
			4'd6:    return VALUE_W'(50);
			4'd7:    return VALUE_W'(40);
			4'd8:    return VALUE_W'(10);
			4'd9:    return VALUE_W'(9);
			4'd10:   return VALUE_W'(5);
			4'd11:   return VALUE_W'(4);
			default: return VALUE_W'(1);
		endcase
	endfunction

	function automatic logic [LETTER_W-1:0] first_ltr(input logic [IDX_W-1:0] idx);
		case (idx)
			4'd0:    return LTR_M;
			4'd1:    return LTR_C;
			4'd2:    return LTR_D;
			4'd3:    return LTR_C;
			4'd4:    return LTR_C;
			4'd5:    return LTR_X;
			4'd6:    return LTR_L;
			4'd7:    return LTR_X;
			4'd8:    return LTR_X;
			4'd9:    return LTR_I;
			4'd10:   return LTR_V;
			4'd11:   return LTR_I;
			default: return LTR_I;
		endcase
	endfunction

	// LTR_NONE means the weight has a single letter
	function automatic logic [LETTER_W-1:0] second_ltr(input logic [IDX_W-1:0] idx);
		case (idx)
			4'd1:    return LTR_M;
			4'd3:    return LTR_D;
			4'd5:    return LTR_C;
			4'd7:    return LTR_L;
			4'd9:    return LTR_X;
			4'd11:   return LTR_V;
			default: return LTR_NONE;
		endcase
	endfunction

	// largest weight not above v
	function automatic logic [IDX_W-1:0] pick_idx(input logic [VALUE_W-1:0] v);
		logic [IDX_W-1:0] idx;
		idx = IDX_W'(NUM_WEIGHTS - 1);
		for (int i = NUM_WEIGHTS - 1; i >= 0; i--) begin
			if (v >= weight(IDX_W'(i)))
				idx = IDX_W'(i);
		end
		return idx;
	endfunction

endpackage

// ===== rtl/rne_if.sv =====
interface rne_num_if;
	logic                             valid;
	logic                             ready;
	logic [rne_pkg::VALUE_W-1:0]      value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface rne_ltr_if;
	logic                             valid;
	logic                             ready;
	logic [rne_pkg::LETTER_W-1:0]     letter;
	logic                             last;
	logic                             range_error;

	modport source (output valid, output letter, output last, output range_error, input ready);
	modport sink   (input valid, input letter, input last, input range_error, output ready);
endinterface

// ===== rtl/rne_front.sv =====
module rne_front (
	rne_num_if.sink          num,
	input  rne_pkg::qstat_t  qstat,
	output logic             push,
	output rne_pkg::qentry_t push_data
);

	assign num.ready = !qstat.full;

	// zero has an empty numeral, so it never reaches the queue
	assign push                  = num.valid && !qstat.full && (num.value != '0);
	assign push_data.value       = num.value;
	assign push_data.range_error = num.value > rne_pkg::MAX_VALID;

endmodule

// ===== rtl/rne_queue.sv =====
module rne_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rne_pkg::qentry_t push_data,
	input  logic             pop,
	output rne_pkg::qstat_t  qstat,
	output rne_pkg::qentry_t head
);

	rne_pkg::qentry_t                   entry_q [rne_pkg::QUEUE_DEPTH];
	logic [rne_pkg::QPTR_W-1:0]         wr_ptr_q;
	logic [rne_pkg::QPTR_W-1:0]         rd_ptr_q;
	logic [rne_pkg::QCNT_W-1:0]         cnt_q;

	assign qstat.valid = cnt_q != '0;
	assign qstat.full  = cnt_q == rne_pkg::QCNT_W'(rne_pkg::QUEUE_DEPTH);
	assign head        = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/rne_back.sv =====
module rne_back (
	input  logic             clk,
	input  logic             arst_n,
	input  rne_pkg::qstat_t  qstat,
	input  rne_pkg::qentry_t head,
	output logic             pop,
	rne_ltr_if.source        ltr
);

	logic                             busy_q;
	logic [rne_pkg::VALUE_W-1:0]      val_q;
	logic                             err_q;
	logic                             sec_valid_q;
	logic [rne_pkg::LETTER_W-1:0]     sec_q;

	logic                             out_valid_q;
	logic [rne_pkg::LETTER_W-1:0]     letter_q;
	logic                             last_q;
	logic                             err_out_q;

	logic                             out_free;
	logic                             step;
	logic [rne_pkg::IDX_W-1:0]        idx;
	logic [rne_pkg::VALUE_W-1:0]      rem;
	logic [rne_pkg::LETTER_W-1:0]     sec_ltr;
	logic                             has_sec;

	logic [rne_pkg::LETTER_W-1:0]     nxt_letter;
	logic                             nxt_last;

	assign out_free = !out_valid_q || ltr.ready;
	assign pop      = !busy_q && qstat.valid;
	assign step     = busy_q && out_free;

	assign idx     = rne_pkg::pick_idx(val_q);
	assign rem     = val_q - rne_pkg::weight(idx);
	assign sec_ltr = rne_pkg::second_ltr(idx);
	assign has_sec = sec_ltr != rne_pkg::LTR_NONE;

	always_comb begin
		if (err_q) begin
			nxt_letter = rne_pkg::LTR_NONE;
			nxt_last   = 1'b1;
		end else if (sec_valid_q) begin
			nxt_letter = sec_q;
			nxt_last   = val_q == '0;
		end else begin
			nxt_letter = rne_pkg::first_ltr(idx);
			nxt_last   = !has_sec && (rem == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			sec_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q      <= 1'b1;
				sec_valid_q <= 1'b0;
			end else if (step) begin
				if (nxt_last)
					busy_q <= 1'b0;
				sec_valid_q <= !err_q && !sec_valid_q && has_sec;
			end
			if (step)
				out_valid_q <= 1'b1;
			else if (ltr.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			val_q <= head.value;
			err_q <= head.range_error;
		end else if (step && !err_q && !sec_valid_q) begin
			val_q <= rem;
			sec_q <= sec_ltr;
		end
		if (step) begin
			letter_q  <= nxt_letter;
			last_q    <= nxt_last;
			err_out_q <= err_q;
		end
	end

	assign ltr.valid       = out_valid_q;
	assign ltr.letter      = letter_q;
	assign ltr.last        = last_q;
	assign ltr.range_error = err_out_q;

endmodule

// ===== rtl/roman_numeral_encoder.sv =====
// Channel   Dir  Payload                          Transaction
// num       in   value[11:0]                      one value to convert
// numeral   out  letter[6:0], last, range_error   one ASCII letter of the numeral
//
// The back end loads a value, then emits its n letters, n = its letter count (1..15);
// one above 3999 gives a single blank letter with range_error, zero is dropped at the front.
// The back end's compare-subtract step emits one letter per cycle while numeral.ready allows it.
// A two-entry queue lets the front take values while the back end runs.
// Reset (arst_n low) empties queue and output register; letters wait while numeral.ready is low.
module roman_numeral_encoder (
	input  logic       clk,
	input  logic       arst_n,
	rne_num_if.sink    num,
	rne_ltr_if.source  numeral
);

	rne_pkg::qstat_t   qstat;
	rne_pkg::qentry_t  push_data;
	rne_pkg::qentry_t  head;
	logic              push;
	logic              pop;

	rne_front u_front (
		.num       (num),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	rne_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.qstat     (qstat),
		.head      (head)
	);

	rne_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qstat  (qstat),
		.head   (head),
		.pop    (pop),
		.ltr    (numeral)
	);

`ifndef SYNTH
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("push into full queue");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> qstat.valid)
		else $error("pop from empty queue");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		numeral.valid && numeral.range_error |->
			numeral.last && (numeral.letter == rne_pkg::LTR_NONE))
		else $error("range error result not a lone blank letter");

	a_zero_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_data.value != '0))
		else $error("zero value entered the queue");
`endif

endmodule

// ===== tb/roman_numeral_encoder_tb.sv =====
`timescale 1ns / 100ps

module roman_numeral_encoder_tb;

	typedef struct packed {
		logic [rne_pkg::LETTER_W-1:0] letter;
		logic                         last;
		logic                         range_error;
	} numeral_ltr_t;

	localparam int unsigned RANDOM_VALUES = 237;
	localparam int unsigned CALM_TAIL     = 40;
	localparam int unsigned DRAIN_CYCLES  = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rne_num_if num_ch ();
	rne_ltr_if ltr_ch ();

	roman_numeral_encoder DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.num     (num_ch),
		.numeral (ltr_ch)
	);

	always #5 clk = ~clk;

	logic [rne_pkg::VALUE_W-1:0] values_todo[$];
	numeral_ltr_t                numeral_due[$];
	numeral_ltr_t                want_ltr;

	int unsigned directed_vals[$] = '{
		0, 1, 4, 5, 9, 10, 14, 40, 49, 90, 99, 400, 444, 900, 999,
		1000, 1994, 2048, 3888, 3999, 4000, 4095, 0
	};

	int unsigned total_values = 0;
	int unsigned values_sent  = 0;
	int unsigned zero_values  = 0;
	int unsigned over_values  = 0;
	int unsigned letters_seen = 0;
	int unsigned mismatches   = 0;
	int unsigned gap_left     = 0;
	int unsigned stall_left   = 0;

	// no idling once the stimulus is nearly used up
	function automatic bit calm();
		return values_todo.size() < CALM_TAIL;
	endfunction

	// decimal-digit expansion; equivalent to greedy subtraction over the weights
	function automatic void predict_numeral(input logic [rne_pkg::VALUE_W-1:0] v);
		logic [rne_pkg::LETTER_W-1:0] run[$];
		logic [rne_pkg::LETTER_W-1:0] unit_l, half_l, next_l;
		int unsigned                  rest, div, digit;
		numeral_ltr_t                 ltr;
		if (v > rne_pkg::MAX_VALID) begin
			ltr.letter      = rne_pkg::LTR_NONE;
			ltr.last        = 1'b1;
			ltr.range_error = 1'b1;
			numeral_due.push_back(ltr);
			return;
		end
		rest = v;
		for (int p = 3; p >= 0; p--) begin
			case (p)
				3: begin
					div = 1000; unit_l = rne_pkg::LTR_M;
					half_l = rne_pkg::LTR_NONE; next_l = rne_pkg::LTR_NONE;
				end
				2: begin
					div = 100; unit_l = rne_pkg::LTR_C;
					half_l = rne_pkg::LTR_D; next_l = rne_pkg::LTR_M;
				end
				1: begin
					div = 10; unit_l = rne_pkg::LTR_X;
					half_l = rne_pkg::LTR_L; next_l = rne_pkg::LTR_C;
				end
				default: begin
					div = 1; unit_l = rne_pkg::LTR_I;
					half_l = rne_pkg::LTR_V; next_l = rne_pkg::LTR_X;
				end
			endcase
			digit = rest / div;
			rest  = rest % div;
			if (p != 3 && digit == 9) begin
				run.push_back(unit_l);
				run.push_back(next_l);
			end else if (p != 3 && digit == 4) begin
				run.push_back(unit_l);
				run.push_back(half_l);
			end else begin
				if (p != 3 && digit >= 5) begin
					run.push_back(half_l);
					digit = digit - 5;
				end
				repeat (digit) run.push_back(unit_l);
			end
		end
		for (int k = 0; k < run.size(); k++) begin
			ltr.letter      = run[k];
			ltr.last        = (k == run.size() - 1);
			ltr.range_error = 1'b0;
			numeral_due.push_back(ltr);
		end
	endfunction

	// value driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_ch.valid <= 1'b0;
			num_ch.value <= '0;
			gap_left = 0;
		end else begin
			if (num_ch.valid && num_ch.ready) begin
				predict_numeral(num_ch.value);
				values_sent++;
			end
			if (!num_ch.valid || num_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					num_ch.valid <= 1'b0;
				end else if (values_todo.size() > 0) begin
					if (!calm() && $urandom_range(0, 5) == 0) begin
						gap_left = $urandom_range(0, 5);
						num_ch.valid <= 1'b0;
					end else begin
						num_ch.valid <= 1'b1;
						num_ch.value <= values_todo.pop_front();
					end
				end else begin
					num_ch.valid <= 1'b0;
				end
			end
		end
	end

	// letter monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ltr_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (ltr_ch.valid && ltr_ch.ready) begin
				letters_seen++;
				if (numeral_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transaction: letter %h last %b range_error %b",
							ltr_ch.letter, ltr_ch.last, ltr_ch.range_error);
				end else begin
					want_ltr = numeral_due.pop_front();
					if (ltr_ch.letter !== want_ltr.letter || ltr_ch.last !== want_ltr.last ||
					    ltr_ch.range_error !== want_ltr.range_error) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected letter %h last %b range_error %b, got %h %b %b",
								want_ltr.letter, want_ltr.last, want_ltr.range_error,
								ltr_ch.letter, ltr_ch.last, ltr_ch.range_error);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				ltr_ch.ready <= 1'b0;
			end else if (!calm() && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 5);
				ltr_ch.ready <= 1'b0;
			end else begin
				ltr_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [rne_pkg::VALUE_W-1:0] v;
		int unsigned                 sel;
		num_ch.valid = 1'b0;
		num_ch.value = '0;
		ltr_ch.ready = 1'b0;
		foreach (directed_vals[k])
			values_todo.push_back(rne_pkg::VALUE_W'(directed_vals[k]));
		for (int k = 0; k < RANDOM_VALUES; k++) begin
			sel = $urandom_range(0, 99);
			if (sel < 8)
				v = '0;
			else if (sel < 20)
				v = rne_pkg::VALUE_W'($urandom_range(4000, 4095));
			else if (sel < 32)
				v = rne_pkg::VALUE_W'($urandom_range(1, 60));
			else
				v = rne_pkg::VALUE_W'($urandom_range(1, 3999));
			values_todo.push_back(v);
		end
		foreach (values_todo[k]) begin
			if (values_todo[k] == 0)
				zero_values++;
			else if (values_todo[k] > rne_pkg::MAX_VALID)
				over_values++;
		end
		total_values = values_todo.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (values_sent < total_values)
			@(posedge clk);
		while (numeral_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d values (%0d zero, %0d above 3999), checked %0d letters.",
			total_values, zero_values, over_values, letters_seen);
		$display("Mismatches: %0d", mismatches);
		if (mismatches == 0 && numeral_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout: %0d of %0d values sent, %0d letters pending",
			values_sent, total_values, numeral_due.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule
